// ===== rtl/core/lpe_pkg.sv =====
package lpe_pkg;

    typedef logic signed [63:0] t_q;

    localparam t_q ONE_Q32     = 64'sh0000_0001_0000_0000;
    localparam t_q INNER_LIMIT = 64'sh0004_0000_0000_0000;
    localparam t_q OUT_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam t_q OUT_MIN     = 64'shFFFF_8000_0000_0000;
    localparam logic [95:0] MAG_LIMIT = 96'h4_0000_0000_0000;
    localparam logic [127:0] RND_HALF = 128'h8000_0000;

    typedef enum logic [2:0] {
        FUNC_VALUE  = 3'd0,
        FUNC_DERIV  = 3'd1,
        FUNC_ANTI   = 3'd2,
        FUNC_SVALUE = 3'd3,
        FUNC_SDERIV = 3'd4,
        FUNC_SANTI  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        KIND_VAL,
        KIND_DER,
        KIND_INT
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_WD,
        S_WU,
        S_S,
        S_WP,
        S_FIN,
        S_WA,
        S_A2,
        S_WB,
        S_OUT
    } t_state;

    // one stage of the multiplier chain
    typedef struct packed {
        logic         vld;
        logic         neg;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [127:0] acc;
    } t_mul_stage;

    typedef struct packed {
        logic vld;
        logic ovf;
        t_q   val;
    } t_mul_res;

    function automatic logic over_limit(input t_q v);
        return (v > INNER_LIMIT) || (v < -INNER_LIMIT);
    endfunction

    function automatic t_mul_stage mul_op(input t_q a, input t_q b);
        t_mul_stage op;
        op.vld = 1'b1;
        op.neg = a[63] ^ b[63];
        op.a   = a[63] ? 64'(-a) : 64'(a);
        op.b   = b[63] ? 64'(-b) : 64'(b);
        op.acc = '0;
        return op;
    endfunction

endpackage

// ===== rtl/core/legendre_polynomial_evaluator.sv =====
// Legendre polynomial evaluator: P_n, P'_n or the antiderivative of P_n, plain or shifted
// (t = 2x-1), by the three-term recurrence in Q.32 fixed point; result in Q16.32, saturated.
// One item is worked at a time. Each recurrence step makes two round trips through a four-cell
// 64x64 multiplier chain for the value and antiderivative, and three for the derivative (one for
// its last step); the antiderivative makes two more after its last step. A finished result waits
// in the output register while the next item is taken.
module legendre_polynomial_evaluator #(
    parameter int MAX_DEGREE  = 63,
    parameter int X_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic [5:0]         i_degree,
    input  logic signed [31:0] i_x_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_result_value,
    output logic               o_bad_request,
    output logic               o_saturated
);

    localparam int NW  = $clog2(MAX_DEGREE + 1);
    localparam int KW  = $clog2(MAX_DEGREE + 2);
    localparam int DW  = (NW > 6) ? NW : 6;
    localparam int SHL = (X_FRAC_BITS <= 32) ? 32 - X_FRAC_BITS : 0;
    localparam int SHR = (X_FRAC_BITS > 32) ? X_FRAC_BITS - 32 : 0;

    logic [32:0] recip_k  [0:MAX_DEGREE+1];
    logic [32:0] recip_2n [0:MAX_DEGREE];

    for (genvar g = 0; g <= MAX_DEGREE + 1; g++) begin : g_rk
        localparam longint unsigned DEN = (g == 0) ? 1 : g;
        localparam longint unsigned RK  = ((64'd1 << 32) + DEN / 2) / DEN;
        assign recip_k[g] = 33'(RK);
    end

    for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_r2
        localparam longint unsigned DEN = (g == 0) ? 1 : g;
        localparam longint unsigned RK  = ((64'd1 << 32) + DEN) / (2 * DEN);
        assign recip_2n[g] = 33'(RK);
    end

    lpe_pkg::t_state     r_state, n_state;
    lpe_pkg::t_kind      r_kind, n_kind;
    logic                r_shift, n_shift;
    logic [NW-1:0]       r_n, n_n;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_ptop, n_ptop;
    logic [KW-1:0]       r_dtop, n_dtop;
    logic [KW-1:0]       r_top, n_top;
    lpe_pkg::t_q         r_t, n_t;
    lpe_pkg::t_q         r_pprev, n_pprev;
    lpe_pkg::t_q         r_pcur, n_pcur;
    lpe_pkg::t_q         r_d, n_d;
    lpe_pkg::t_q         r_u, n_u;
    lpe_pkg::t_q         r_v, n_v;
    logic                r_ovf, n_ovf;
    logic                r_bad, n_bad;
    lpe_pkg::t_mul_stage r_op, n_op;
    logic                r_out_vld, n_out_vld;
    logic signed [47:0]  r_res, n_res;
    logic                r_bad_o, n_bad_o;
    logic                r_sat, n_sat;

    lpe_pkg::t_mul_res mres;

    logic [DW-1:0] deg_w;
    logic [NW-1:0] n_in;
    lpe_pkg::t_q   tq;
    lpe_pkg::t_q   k_q;
    lpe_pkg::t_q   dsum;
    lpe_pkg::t_q   sval;
    lpe_pkg::t_q   diff;
    logic          last;
    logic          neg;

    lpe_mul_chain u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (r_op),
        .o_res  (mres)
    );

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_shift <= n_shift;
        r_n     <= n_n;
        r_k     <= n_k;
        r_ptop  <= n_ptop;
        r_dtop  <= n_dtop;
        r_top   <= n_top;
        r_t     <= n_t;
        r_pprev <= n_pprev;
        r_pcur  <= n_pcur;
        r_d     <= n_d;
        r_u     <= n_u;
        r_v     <= n_v;
        r_ovf   <= n_ovf;
        r_bad   <= n_bad;
        r_res   <= n_res;
        r_bad_o <= n_bad_o;
        r_sat   <= n_sat;
        if (!i_rst_n) begin
            r_state   <= lpe_pkg::S_IDLE;
            r_op      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_shift   = r_shift;
        n_n       = r_n;
        n_k       = r_k;
        n_ptop    = r_ptop;
        n_dtop    = r_dtop;
        n_top     = r_top;
        n_t       = r_t;
        n_pprev   = r_pprev;
        n_pcur    = r_pcur;
        n_d       = r_d;
        n_u       = r_u;
        n_v       = r_v;
        n_ovf     = r_ovf;
        n_bad     = r_bad;
        n_op      = r_op;
        n_op.vld  = 1'b0;
        n_out_vld = r_out_vld;
        n_res     = r_res;
        n_bad_o   = r_bad_o;
        n_sat     = r_sat;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        deg_w = DW'(i_degree);
        n_in  = (deg_w > DW'(MAX_DEGREE)) ? NW'(MAX_DEGREE) : NW'(deg_w);
        tq    = (lpe_pkg::t_q'(i_x_value) <<< SHL) >>> SHR;

        k_q  = lpe_pkg::t_q'(r_k);
        dsum = k_q * r_pcur + mres.val;
        sval = (lpe_pkg::t_q'({r_k, 1'b0}) - 1) * r_u - (k_q - 1) * r_pprev;
        diff = r_pcur - mres.val;
        last = (r_k == r_top);
        neg  = r_t[63] && ((r_kind == lpe_pkg::KIND_VAL) ? r_n[0] : !r_n[0]);

        case (r_state)
            lpe_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_n     = n_in;
                    n_k     = KW'(1);
                    n_pprev = '0;
                    n_pcur  = lpe_pkg::ONE_Q32;
                    n_d     = '0;
                    n_v     = '0;
                    n_ovf   = 1'b0;
                    n_bad   = 1'b0;
                    n_shift = 1'b0;
                    n_kind  = lpe_pkg::KIND_VAL;
                    case (i_func)
                        lpe_pkg::FUNC_VALUE:  n_kind = lpe_pkg::KIND_VAL;
                        lpe_pkg::FUNC_DERIV:  n_kind = lpe_pkg::KIND_DER;
                        lpe_pkg::FUNC_ANTI:   n_kind = lpe_pkg::KIND_INT;
                        lpe_pkg::FUNC_SVALUE: begin
                            n_kind  = lpe_pkg::KIND_VAL;
                            n_shift = 1'b1;
                        end
                        lpe_pkg::FUNC_SDERIV: begin
                            n_kind  = lpe_pkg::KIND_DER;
                            n_shift = 1'b1;
                        end
                        lpe_pkg::FUNC_SANTI: begin
                            n_kind  = lpe_pkg::KIND_INT;
                            n_shift = 1'b1;
                        end
                        default: n_bad = 1'b1;
                    endcase
                    if (n_kind == lpe_pkg::KIND_INT && n_in == '0) begin
                        n_bad = 1'b1;
                    end
                    n_t = n_shift ? (tq <<< 1) - lpe_pkg::ONE_Q32 : tq;
                    case (n_kind)
                        lpe_pkg::KIND_DER: begin
                            n_ptop = (n_in == '0) ? '0 : KW'(n_in) - KW'(1);
                            n_dtop = KW'(n_in);
                            n_top  = KW'(n_in);
                        end
                        lpe_pkg::KIND_INT: begin
                            n_ptop = KW'(n_in) + KW'(1);
                            n_dtop = '0;
                            n_top  = KW'(n_in) + KW'(1);
                        end
                        default: begin
                            n_ptop = KW'(n_in);
                            n_dtop = '0;
                            n_top  = KW'(n_in);
                        end
                    endcase
                    if (n_bad) begin
                        n_state = lpe_pkg::S_OUT;
                    end else if (n_top == '0) begin
                        n_state = lpe_pkg::S_FIN;
                    end else begin
                        n_state = lpe_pkg::S_STEP;
                    end
                end
            end

            lpe_pkg::S_STEP: begin
                if (r_k <= r_dtop) begin
                    n_op    = lpe_pkg::mul_op(r_t, r_d);
                    n_state = lpe_pkg::S_WD;
                end else begin
                    n_op    = lpe_pkg::mul_op(r_t, r_pcur);
                    n_state = lpe_pkg::S_WU;
                end
            end

            lpe_pkg::S_WD: begin
                if (mres.vld) begin
                    if (mres.ovf || lpe_pkg::over_limit(dsum)) begin
                        n_ovf   = 1'b1;
                        n_state = lpe_pkg::S_FIN;
                    end else begin
                        n_d = dsum;
                        if (r_k <= r_ptop) begin
                            n_op    = lpe_pkg::mul_op(r_t, r_pcur);
                            n_state = lpe_pkg::S_WU;
                        end else if (last) begin
                            n_state = lpe_pkg::S_FIN;
                        end else begin
                            n_k     = r_k + KW'(1);
                            n_state = lpe_pkg::S_STEP;
                        end
                    end
                end
            end

            lpe_pkg::S_WU: begin
                if (mres.vld) begin
                    if (mres.ovf) begin
                        n_ovf   = 1'b1;
                        n_state = lpe_pkg::S_FIN;
                    end else begin
                        n_u     = mres.val;
                        n_state = lpe_pkg::S_S;
                    end
                end
            end

            lpe_pkg::S_S: begin
                n_op    = lpe_pkg::mul_op(sval, lpe_pkg::t_q'(recip_k[r_k]));
                n_state = lpe_pkg::S_WP;
            end

            lpe_pkg::S_WP: begin
                if (mres.vld) begin
                    if (mres.ovf) begin
                        n_ovf   = 1'b1;
                        n_state = lpe_pkg::S_FIN;
                    end else begin
                        n_pprev = r_pcur;
                        n_pcur  = mres.val;
                        if (last) begin
                            n_state = lpe_pkg::S_FIN;
                        end else begin
                            n_k     = r_k + KW'(1);
                            n_state = lpe_pkg::S_STEP;
                        end
                    end
                end
            end

            lpe_pkg::S_FIN: begin
                if (r_ovf) begin
                    n_state = lpe_pkg::S_OUT;
                end else begin
                    case (r_kind)
                        lpe_pkg::KIND_VAL: begin
                            n_v     = r_pcur;
                            n_state = lpe_pkg::S_OUT;
                        end
                        lpe_pkg::KIND_DER: begin
                            n_v     = r_shift ? (r_d <<< 1) : r_d;
                            n_state = lpe_pkg::S_OUT;
                        end
                        default: begin
                            n_op    = lpe_pkg::mul_op(r_t, r_pprev);
                            n_state = lpe_pkg::S_WA;
                        end
                    endcase
                end
            end

            lpe_pkg::S_WA: begin
                if (mres.vld) begin
                    if (mres.ovf || lpe_pkg::over_limit(diff)) begin
                        n_ovf   = 1'b1;
                        n_state = lpe_pkg::S_OUT;
                    end else begin
                        n_u     = diff;
                        n_state = lpe_pkg::S_A2;
                    end
                end
            end

            lpe_pkg::S_A2: begin
                n_op = lpe_pkg::mul_op(r_u, r_shift ? lpe_pkg::t_q'(recip_2n[r_n])
                                                    : lpe_pkg::t_q'(recip_k[KW'(r_n)]));
                n_state = lpe_pkg::S_WB;
            end

            lpe_pkg::S_WB: begin
                if (mres.vld) begin
                    n_ovf   = mres.ovf;
                    n_v     = mres.val;
                    n_state = lpe_pkg::S_OUT;
                end
            end

            lpe_pkg::S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_bad_o   = r_bad;
                    n_sat     = 1'b0;
                    n_res     = r_v[47:0];
                    if (r_bad) begin
                        n_res = '0;
                    end else if (r_ovf) begin
                        n_res = neg ? lpe_pkg::OUT_MIN[47:0] : lpe_pkg::OUT_MAX[47:0];
                        n_sat = 1'b1;
                    end else if (r_v > lpe_pkg::OUT_MAX) begin
                        n_res = lpe_pkg::OUT_MAX[47:0];
                        n_sat = 1'b1;
                    end else if (r_v < lpe_pkg::OUT_MIN) begin
                        n_res = lpe_pkg::OUT_MIN[47:0];
                        n_sat = 1'b1;
                    end
                    n_state = lpe_pkg::S_IDLE;
                end
            end

            default: n_state = lpe_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready     = (r_state == lpe_pkg::S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_res;
    assign o_bad_request  = r_bad_o;
    assign o_saturated    = r_sat;

    a_res_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mres.vld |-> (r_state == lpe_pkg::S_WD || r_state == lpe_pkg::S_WU ||
                      r_state == lpe_pkg::S_WP || r_state == lpe_pkg::S_WA ||
                      r_state == lpe_pkg::S_WB))
        else $error("multiplier result outside a wait state");

    a_idle_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_op.vld && !mres.vld)
        else $error("multiply in flight while idle");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lpe_pkg::S_STEP |-> (r_k != '0) && (r_k <= r_top))
        else $error("recurrence index out of range");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_request |-> (o_result_value == '0) && !o_saturated)
        else $error("bad request with nonzero result");

endmodule

// ===== rtl/core/lpe_mul_cell.sv =====
module lpe_mul_cell #(
    parameter int A_DIG = 0,
    parameter int B_DIG = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpe_pkg::t_mul_stage i_stage,
    output lpe_pkg::t_mul_stage o_stage
);

    logic [63:0]         pp;
    lpe_pkg::t_mul_stage r_stage;
    lpe_pkg::t_mul_stage n_stage;

    always_comb begin
        pp = i_stage.a[32*A_DIG +: 32] * i_stage.b[32*B_DIG +: 32];
        n_stage = i_stage;
        n_stage.acc = i_stage.acc + (128'(pp) << (32 * (A_DIG + B_DIG)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/core/lpe_mul_chain.sv =====
module lpe_mul_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpe_pkg::t_mul_stage i_op,
    output lpe_pkg::t_mul_res   o_res
);

    lpe_pkg::t_mul_stage st [0:4];
    logic [127:0]        rnd;
    logic [95:0]         mag;

    assign st[0] = i_op;

    for (genvar g = 0; g < 4; g++) begin : g_cell
        lpe_mul_cell #(
            .A_DIG(g / 2),
            .B_DIG(g % 2)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(st[g]),
            .o_stage(st[g+1])
        );
    end

    // round half away from zero back to Q.32
    always_comb begin
        rnd = st[4].acc + lpe_pkg::RND_HALF;
        mag = rnd[127:32];
        o_res.vld = st[4].vld;
        o_res.ovf = mag > lpe_pkg::MAG_LIMIT;
        o_res.val = st[4].neg ? -lpe_pkg::t_q'(mag[63:0]) : lpe_pkg::t_q'(mag[63:0]);
    end

endmodule
